### rtl/stc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

   localparam int BYTE_W     = 8;
   localparam int LINE_IDX_W = 9;
   localparam int COLUMN_W   = 7;
   localparam int LEN_OUT_W  = 8;

   localparam logic [BYTE_W-1:0] CHR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHR_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CHR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;

   localparam int TAB_STOP = 4;
   localparam int MIN_COLS = 8;

   localparam logic [BYTE_W-1:0] VIS_RESET = 8'd112;

   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef logic [2:0] stc_cls_type;

   localparam stc_cls_type CLS_OTHER = 3'd0;
   localparam stc_cls_type CLS_CR    = 3'd1;
   localparam stc_cls_type CLS_LF    = 3'd2;
   localparam stc_cls_type CLS_FF    = 3'd3;
   localparam stc_cls_type CLS_BS    = 3'd4;
   localparam stc_cls_type CLS_TAB   = 3'd5;

   typedef struct packed {
      logic load_req;
      logic clear_all;
      logic backspace;
      logic commit_start;
      logic copy_step;
      logic commit_end;
      logic append;
      logic append_space;
      logic finish;
   } stc_cmd_type;

   typedef struct packed {
      logic        func_read;
      stc_cls_type cls;
      logic        at_width;
      logic        tab_last;
      logic        copy_done;
   } stc_sts_type;

endpackage

`default_nettype wire

### rtl/scrollback_text_console.sv
// Text console with a scrollback ring of committed lines.
// Request channel: drive req_* and raise start; the request is taken at a
// clock edge where start is high and busy is low. req_func 0 puts
// req_data_byte into the current line, 1 reads one cell (req_line_index,
// req_column). Each request gives exactly one response: rsp_valid is high
// for one cycle with rsp_read_char, rsp_cell_valid, rsp_line_count and
// rsp_current_length; the receiver must take it then, it cannot stall.
// A request keeps busy high until its response is registered; busy falls as
// rsp_valid rises, so the next request can be taken at the edge that takes
// the response. TAB writes one space per cycle up to the next tab stop or the wrap width.
// A line commit (LF, or a byte at the wrap width) copies the live line into
// the ring one cell per cycle through the single write port of the cell
// memory.
// csr_wr_en / csr_wr_data write the wrap width; the user must write it only while idle, the block does not enforce it.
// Reset empties the ring and the live line and sets the wrap width to 112;
// memory contents are not cleared, stale cells are never read.
`timescale 1ns / 1ps
`default_nettype none

module scrollback_text_console #(
   parameter int RING_ROWS = 256,
   parameter int LINE_COLS = 128
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_func,
   input  wire logic [stc_pkg::BYTE_W-1:0]         req_data_byte,
   input  wire logic [stc_pkg::LINE_IDX_W-1:0]     req_line_index,
   input  wire logic [stc_pkg::COLUMN_W-1:0]       req_column,
   input  wire logic                               csr_wr_en,
   input  wire logic [stc_pkg::BYTE_W-1:0]         csr_wr_data,
   output logic                                    rsp_valid,
   output logic      [stc_pkg::BYTE_W-1:0]         rsp_read_char,
   output logic                                    rsp_cell_valid,
   output logic      [stc_pkg::LINE_IDX_W-1:0]     rsp_line_count,
   output logic      [stc_pkg::LEN_OUT_W-1:0]      rsp_current_length
);

   import stc_pkg::*;

   stc_cmd_type cmd;
   stc_sts_type sts;

   stc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   stc_dp #(
      .RING_ROWS (RING_ROWS),
      .LINE_COLS (LINE_COLS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_func),
      .req_data_byte      (req_data_byte),
      .req_line_index     (req_line_index),
      .req_column         (req_column),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_read_char      (rsp_read_char),
      .rsp_cell_valid     (rsp_cell_valid),
      .rsp_line_count     (rsp_line_count),
      .rsp_current_length (rsp_current_length)
   );

endmodule

`default_nettype wire

### rtl/stc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/stc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module stc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire stc_pkg::stc_sts_type sts,
   output stc_pkg::stc_cmd_type      cmd
);

   import stc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_COPY = 2'd2;
   localparam logic [1:0] ST_TAB  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.func_read) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               case (sts.cls)
                  CLS_CR: begin
                     cmd.finish = 1'b1;
                     state_in   = ST_IDLE;
                  end
                  CLS_LF: begin
                     cmd.commit_start = 1'b1;
                     state_in         = ST_COPY;
                  end
                  CLS_FF: begin
                     cmd.clear_all = 1'b1;
                     cmd.finish    = 1'b1;
                     state_in      = ST_IDLE;
                  end
                  CLS_BS: begin
                     cmd.backspace = 1'b1;
                     cmd.finish    = 1'b1;
                     state_in      = ST_IDLE;
                  end
                  CLS_TAB: begin
                     if (sts.at_width) begin
                        cmd.finish = 1'b1;
                        state_in   = ST_IDLE;
                     end else begin
                        cmd.append       = 1'b1;
                        cmd.append_space = 1'b1;
                        if (sts.tab_last) begin
                           cmd.finish = 1'b1;
                           state_in   = ST_IDLE;
                        end else begin
                           state_in = ST_TAB;
                        end
                     end
                  end
                  default: begin
                     if (sts.at_width) begin
                        cmd.commit_start = 1'b1;
                        state_in         = ST_COPY;
                     end else begin
                        cmd.append = 1'b1;
                        cmd.finish = 1'b1;
                        state_in   = ST_IDLE;
                     end
                  end
               endcase
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (sts.copy_done) begin
               cmd.commit_end = 1'b1;
               cmd.append     = (sts.cls == CLS_OTHER);
               cmd.finish     = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_TAB: begin
            cmd.append       = 1'b1;
            cmd.append_space = 1'b1;
            if (sts.tab_last) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

### rtl/stc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module stc_dp #(
   parameter int RING_ROWS = 256,
   parameter int LINE_COLS = 128
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_func,
   input  wire logic [stc_pkg::BYTE_W-1:0]            req_data_byte,
   input  wire logic [stc_pkg::LINE_IDX_W-1:0]        req_line_index,
   input  wire logic [stc_pkg::COLUMN_W-1:0]          req_column,
   input  wire logic                                  csr_wr_en,
   input  wire logic [stc_pkg::BYTE_W-1:0]            csr_wr_data,
   input  wire stc_pkg::stc_cmd_type                  cmd,
   output stc_pkg::stc_sts_type                       sts,
   output logic                                       rsp_valid,
   output logic      [stc_pkg::BYTE_W-1:0]            rsp_read_char,
   output logic                                       rsp_cell_valid,
   output logic      [stc_pkg::LINE_IDX_W-1:0]        rsp_line_count,
   output logic      [stc_pkg::LEN_OUT_W-1:0]         rsp_current_length
);

   import stc_pkg::*;

   localparam int ROW_W  = $clog2(RING_ROWS);
   localparam int RW_W   = ROW_W + 1;
   localparam int COL_W  = $clog2(LINE_COLS);
   localparam int LEN_W  = $clog2(LINE_COLS + 1);
   localparam int CNT_W  = $clog2(RING_ROWS + 1);
   localparam int CMP_W  = (LEN_W > COLUMN_W) ? LEN_W : COLUMN_W;
   localparam int LCMP_W = (CNT_W > LINE_IDX_W) ? CNT_W : LINE_IDX_W;
   localparam int CELL_DEPTH = RING_ROWS * (1 << COL_W);

   // configuration
   logic [BYTE_W-1:0] csr_vis_ff;

   // console state
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [ROW_W-1:0] oldest_ff, oldest_in;
   logic [LEN_W-1:0] len_ff,    len_in;
   logic [LEN_W-1:0] fzp_ff,    fzp_in;

   // latched request
   logic                  req_func_ff, req_func_in;
   logic [BYTE_W-1:0]     req_byte_ff, req_byte_in;
   logic [LINE_IDX_W-1:0] req_line_ff, req_line_in;
   logic [COLUMN_W-1:0]   req_col_ff,  req_col_in;

   // line copy
   logic [ROW_W-1:0] copy_row_ff, copy_row_in;
   logic [LEN_W-1:0] copy_n_ff,   copy_n_in;
   logic [LEN_W-1:0] copy_idx_ff, copy_idx_in;

   // response
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_char_ff,  rsp_char_in;
   logic              rsp_cell_ff,  rsp_cell_in;

   logic [LEN_W-1:0]  width_w;
   logic [LEN_W:0]    len_p1;
   logic [RW_W-1:0]   rd_sum;
   logic [ROW_W-1:0]  rd_row;
   logic [RW_W-1:0]   cm_sum;
   logic [ROW_W-1:0]  cm_row;
   logic              ring_full;
   logic [ROW_W-1:0]  oldest_inc;
   logic [LEN_W-1:0]  commit_n;
   stc_cls_type       cls;

   logic              col_ok;
   logic              rd_valid;
   logic [BYTE_W-1:0] rd_char;

   logic [LEN_W-1:0]  base_len;
   logic [LEN_W-1:0]  base_fzp;
   logic [BYTE_W-1:0] app_char;
   logic [LEN_W-1:0]  len_dec;

   logic                     live_wr_en;
   logic [COL_W-1:0]         live_wr_addr;
   logic [COL_W-1:0]         live_rd_addr;
   logic [BYTE_W-1:0]        live_rd_data;
   logic                     cell_wr_en;
   logic [ROW_W+COL_W-1:0]   cell_wr_addr;
   logic [ROW_W+COL_W-1:0]   cell_rd_addr;
   logic [BYTE_W-1:0]        cell_rd_data;
   logic [LEN_W-1:0]         rowlen_rd_data;

   // effective wrap width, clamped to MIN_COLS..LINE_COLS
   always_comb begin
      if (csr_vis_ff < BYTE_W'(MIN_COLS)) begin
         width_w = LEN_W'(MIN_COLS);
      end else if ({1'b0, csr_vis_ff} > (BYTE_W + 1)'(LINE_COLS)) begin
         width_w = LEN_W'(LINE_COLS);
      end else begin
         width_w = LEN_W'(csr_vis_ff);
      end
   end

   always_comb begin
      case (req_byte_ff)
         CHR_CR:  cls = CLS_CR;
         CHR_LF:  cls = CLS_LF;
         CHR_FF:  cls = CLS_FF;
         CHR_BS:  cls = CLS_BS;
         CHR_TAB: cls = CLS_TAB;
         default: cls = CLS_OTHER;
      endcase
   end

   assign len_p1 = {1'b0, len_ff} + (LEN_W + 1)'(1);

   assign sts.func_read = (req_func_ff == FUNC_READ);
   assign sts.cls       = cls;
   assign sts.at_width  = (len_ff >= width_w);
   assign sts.tab_last  = ((len_p1 & (LEN_W + 1)'(TAB_STOP - 1)) == '0) ||
                          (len_p1 >= {1'b0, width_w});
   assign sts.copy_done = (copy_idx_ff == copy_n_ff);

   // ring row of a read request, taken straight from the ports
   assign rd_sum = RW_W'(oldest_ff) + RW_W'(req_line_index);
   assign rd_row = (rd_sum >= RW_W'(RING_ROWS)) ? ROW_W'(rd_sum - RW_W'(RING_ROWS))
                                                 : ROW_W'(rd_sum);

   // row that the next commit fills
   assign ring_full  = (count_ff == CNT_W'(RING_ROWS));
   assign cm_sum     = RW_W'(oldest_ff) + RW_W'(count_ff);
   assign cm_row     = ring_full ? oldest_ff :
                       (cm_sum >= RW_W'(RING_ROWS)) ? ROW_W'(cm_sum - RW_W'(RING_ROWS))
                                                     : ROW_W'(cm_sum);
   assign oldest_inc = (oldest_ff == ROW_W'(RING_ROWS - 1)) ? '0
                                                             : ROW_W'(oldest_ff + 1'b1);
   assign commit_n   = (fzp_ff < len_ff) ? fzp_ff : len_ff;

   // read result
   always_comb begin
      col_ok   = (CMP_W'(req_col_ff) < CMP_W'(LINE_COLS));
      rd_valid = 1'b0;
      rd_char  = '0;
      if (LCMP_W'(req_line_ff) < LCMP_W'(count_ff)) begin
         rd_valid = col_ok && (CMP_W'(req_col_ff) < CMP_W'(rowlen_rd_data));
         rd_char  = cell_rd_data;
      end else if (LCMP_W'(req_line_ff) == LCMP_W'(count_ff)) begin
         rd_valid = col_ok && (CMP_W'(req_col_ff) < CMP_W'(len_ff));
         rd_char  = live_rd_data;
      end
      if (!rd_valid) begin
         rd_char = '0;
      end
   end

   assign base_len = cmd.commit_end ? '0 : len_ff;
   assign base_fzp = cmd.commit_end ? LEN_W'(LINE_COLS) : fzp_ff;
   assign app_char = cmd.append_space ? CHR_SPACE : req_byte_ff;
   assign len_dec  = len_ff - LEN_W'(1);

   always_comb begin
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      len_in       = len_ff;
      fzp_in       = fzp_ff;
      req_func_in  = req_func_ff;
      req_byte_in  = req_byte_ff;
      req_line_in  = req_line_ff;
      req_col_in   = req_col_ff;
      copy_row_in  = copy_row_ff;
      copy_n_in    = copy_n_ff;
      copy_idx_in  = copy_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_cell_in  = rsp_cell_ff;

      if (cmd.load_req) begin
         req_func_in = req_func;
         req_byte_in = req_data_byte;
         req_line_in = req_line_index;
         req_col_in  = req_column;
      end

      if (cmd.clear_all) begin
         count_in  = '0;
         oldest_in = '0;
         len_in    = '0;
         fzp_in    = LEN_W'(LINE_COLS);
      end

      if (cmd.backspace && (len_ff != '0)) begin
         len_in = len_dec;
         if (fzp_ff >= len_dec) begin
            fzp_in = LEN_W'(LINE_COLS);
         end
      end

      if (cmd.commit_start) begin
         copy_row_in = cm_row;
         copy_n_in   = commit_n;
         copy_idx_in = '0;
         if (ring_full) begin
            oldest_in = oldest_inc;
         end else begin
            count_in = CNT_W'(count_ff + 1'b1);
         end
      end

      if (cmd.copy_step) begin
         copy_idx_in = LEN_W'(copy_idx_ff + 1'b1);
      end

      if (cmd.commit_end) begin
         len_in = '0;
         fzp_in = LEN_W'(LINE_COLS);
      end

      if (cmd.append) begin
         len_in = LEN_W'(base_len + 1'b1);
         if ((app_char == CHR_NUL) && (base_fzp > base_len)) begin
            fzp_in = base_len;
         end else begin
            fzp_in = base_fzp;
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = sts.func_read ? rd_char : '0;
         rsp_cell_in  = sts.func_read ? rd_valid : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_vis_ff   <= VIS_RESET;
         count_ff     <= '0;
         oldest_ff    <= '0;
         len_ff       <= '0;
         fzp_ff       <= LEN_W'(LINE_COLS);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_vis_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         len_ff       <= len_in;
         fzp_ff       <= fzp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_func_ff <= req_func_in;
      req_byte_ff <= req_byte_in;
      req_line_ff <= req_line_in;
      req_col_ff  <= req_col_in;
      copy_row_ff <= copy_row_in;
      copy_n_ff   <= copy_n_in;
      copy_idx_ff <= copy_idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   // live line: append writes, copy or read request reads
   assign live_wr_en   = cmd.append;
   assign live_wr_addr = COL_W'(base_len);
   assign live_rd_addr = cmd.copy_step ? COL_W'(copy_idx_ff) : COL_W'(req_column);

   stc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (1 << COL_W)
   ) u_live_ram (
      .clock   (clock),
      .wr_en   (live_wr_en),
      .wr_addr (live_wr_addr),
      .wr_data (app_char),
      .rd_addr (live_rd_addr),
      .rd_data (live_rd_data)
   );

   // ring cells: each write lands in the cycle after the live read of its cell
   assign cell_wr_en   = cmd.copy_step && (copy_idx_ff != '0);
   assign cell_wr_addr = {copy_row_ff, COL_W'(copy_idx_ff - LEN_W'(1))};
   assign cell_rd_addr = {rd_row, COL_W'(req_column)};

   stc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CELL_DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (live_rd_data),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_data)
   );

   stc_ram #(
      .WIDTH (LEN_W),
      .DEPTH (1 << ROW_W)
   ) u_rowlen_ram (
      .clock   (clock),
      .wr_en   (cmd.commit_end),
      .wr_addr (copy_row_ff),
      .wr_data (copy_n_ff),
      .rd_addr (rd_row),
      .rd_data (rowlen_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_char      = rsp_char_ff;
   assign rsp_cell_valid     = rsp_cell_ff;
   assign rsp_line_count     = LINE_IDX_W'(count_ff);
   assign rsp_current_length = LEN_OUT_W'(len_ff);

endmodule

`default_nettype wire

### rtl/stc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module stc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [7:0] rsp_read_char,
   input wire logic       rsp_cell_valid
);

   // an accepted request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted request");

   // no response in the cycle right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("response too early");

   // a response closes the request: block idle, and busy the cycle before
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("response without finished request");

   // an invalid cell reads as zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_cell_valid) |-> (rsp_read_char == 8'd0))
      else $error("nonzero character on invalid cell");

endmodule

bind scrollback_text_console stc_checker u_stc_checker (.*);

`default_nettype wire
